// File: rtl/core/dfs_pkg.sv
// dfs_pkg: shared types and constants for the depth frame statistics core
// no dependencies
package dfs_pkg;

  localparam int RAW_W   = 32;
  localparam int DEPTH_W = 32;
  localparam int RATIO_W = 17;

  localparam logic [0:0]  REG_DEPTH_MODE = 1'b0;
  localparam logic [0:0]  REG_SAT_DEPTH  = 1'b1;
  localparam logic [31:0] SAT_DEPTH_RST  = 32'd16640000;
  localparam logic [31:0] DEPTH_ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    PIX_NAN_INF,
    PIX_ZERO_NEG,
    PIX_USEFUL,
    PIX_FAR
  } pix_class_t;

  // one classified pixel between front and back
  typedef struct packed {
    pix_class_t          cls;
    logic [DEPTH_W-1:0]  depth;
    logic                last;
  } pix_item_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIVIDE,
    ST_OUTPUT
  } back_state_t;

endpackage

// File: rtl/core/dfs_front.sv
// dfs_front: pixel conversion to 1/256 mm fixed point and classification
// depends on dfs_pkg
module dfs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [31:0]              in_pixel_raw,
  input  logic                     in_last_in_frame,
  input  logic                     depth_mode,
  input  logic [31:0]              saturation_depth,
  output logic                     q_valid,
  output dfs_pkg::pix_item_t       q_item,
  input  logic                     q_stall
);
  import dfs_pkg::*;

  // stage 1: classify, register mantissa and exponent
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_kind_r;   // 0 nan/inf, 1 zero/neg, 2 positive
  logic        s1_float_r;
  logic [23:0] s1_mant_r;
  logic [7:0]  s1_exp_r;
  logic [15:0] s1_mm_r;
  logic        s1_last_r;
  // stage 2: product registered
  logic        s2_valid_r;
  logic [1:0]  s2_kind_r;
  logic        s2_float_r;
  logic [41:0] s2_prod_r;
  logic [7:0]  s2_exp_r;
  logic [15:0] s2_mm_r;
  logic        s2_last_r;
  logic        out_valid_r;
  pix_item_t   out_item_r;

  logic adv_out, adv2, adv1;
  assign adv_out = !out_valid_r || !q_stall;
  assign adv2    = !s2_valid_r || adv_out;
  assign adv1    = !s1_valid_r || adv2;
  assign in_stall = !adv1;
  assign q_valid = out_valid_r;
  assign q_item  = out_item_r;

  logic [7:0]  e_raw;
  logic [1:0]  kind;
  assign e_raw = in_pixel_raw[30:23];
  always_comb begin
    if (depth_mode == 1'b0) begin
      if (e_raw == 8'hFF) kind = 2'd0;
      else if (!in_pixel_raw[31] && in_pixel_raw[30:0] != 31'd0) kind = 2'd2;
      else kind = 2'd1;
    end else begin
      kind = (in_pixel_raw[15:0] != 16'd0) ? 2'd2 : 2'd1;
    end
    s1_valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_kind_r  <= kind;
      s1_float_r <= !depth_mode;
      s1_mant_r  <= {e_raw != 8'd0, in_pixel_raw[22:0]};
      s1_exp_r   <= (e_raw == 8'd0) ? 8'd1 : e_raw;
      s1_mm_r    <= in_pixel_raw[15:0];
      s1_last_r  <= in_last_in_frame;
    end
    if (adv2) begin
      s2_kind_r  <= s1_kind_r;
      s2_float_r <= s1_float_r;
      s2_prod_r  <= 42'(s1_mant_r) * 42'd256000;
      s2_exp_r   <= s1_exp_r;
      s2_mm_r    <= s1_mm_r;
      s2_last_r  <= s1_last_r;
    end
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= s1_valid_nxt;
      if (adv2) s2_valid_r <= s1_valid_r;
      if (adv_out) out_valid_r <= s2_valid_r;
    end
  end

  // scale the product by the exponent, saturating
  logic [DEPTH_W-1:0] depth;
  logic [7:0]         sh;
  logic [73:0]        shl;
  logic [41:0]        shr;
  always_comb begin
    sh  = 8'd0;
    shl = '0;
    shr = '0;
    if (!s2_float_r) begin
      depth = {8'd0, s2_mm_r, 8'd0};
    end else if (s2_exp_r >= 8'd150) begin
      sh = s2_exp_r - 8'd150;
      if (sh >= 8'd32) begin
        depth = DEPTH_ALL_ONES;
      end else begin
        shl = 74'(s2_prod_r) << sh[4:0];
        depth = (shl[73:32] != '0) ? DEPTH_ALL_ONES : shl[31:0];
      end
    end else begin
      sh = 8'd150 - s2_exp_r;
      shr = (sh >= 8'd64) ? 42'd0 : (s2_prod_r >> sh[5:0]);
      depth = (shr[41:32] != '0) ? DEPTH_ALL_ONES : shr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_item_r.last  <= s2_last_r;
      out_item_r.depth <= (s2_kind_r == 2'd2) ? depth : '0;
      priority if (s2_kind_r == 2'd0) out_item_r.cls <= PIX_NAN_INF;
      else if (s2_kind_r == 2'd1) out_item_r.cls <= PIX_ZERO_NEG;
      else if (depth < saturation_depth) out_item_r.cls <= PIX_USEFUL;
      else out_item_r.cls <= PIX_FAR;
    end
  end
endmodule

// File: rtl/core/dfs_fifo.sv
// dfs_fifo: short queue of classified pixels between front and back
// depends on dfs_pkg
module dfs_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  dfs_pkg::pix_item_t wr_item,
  output logic               rd_valid,
  output dfs_pkg::pix_item_t rd_item,
  input  logic               rd_stall
);
  import dfs_pkg::*;

  pix_item_t  mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_stall = (cnt_r == 3'd4);
  assign rd_valid = (cnt_r != 3'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end
endmodule

// File: rtl/core/dfs_divider.sv
// dfs_divider: radix-2 restoring divider, one quotient bit per cycle
// no package dependency
module dfs_divider #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign busy  = (cnt_r != '0);
  assign quot  = q_r;
  assign trial = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= diff;
        q_r   <= {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NUM_W-2:0], 1'b0};
      end
    end
    if (!rst_n) cnt_r <= '0;
    else if (start) cnt_r <= CNT_W'(NUM_W);
    else if (busy) cnt_r <= cnt_r - 1'b1;
  end
endmodule

// File: rtl/core/dfs_back.sv
// dfs_back: frame accumulators and end-of-frame result computation
// depends on dfs_pkg and dfs_divider
module dfs_back #(
  parameter int CNT_W = 22,
  parameter int SUM_W = 54,
  parameter int MAX_PIX = 2097152
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_stall,
  input  dfs_pkg::pix_item_t q_item,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [21:0]        out_total_pixels,
  output logic [21:0]        out_nan_inf_count,
  output logic [21:0]        out_positive_count,
  output logic [21:0]        out_useful_count,
  output logic [21:0]        out_far_count,
  output logic [21:0]        out_zero_negative_count,
  output logic [31:0]        out_min_depth,
  output logic [31:0]        out_max_depth,
  output logic [31:0]        out_mean_depth,
  output logic [31:0]        out_mean_useful_depth,
  output logic [16:0]        out_valid_ratio,
  output logic [16:0]        out_useful_ratio
);
  import dfs_pkg::*;

  localparam int NUM_W = (SUM_W > CNT_W + 16) ? SUM_W : CNT_W + 16;

  back_state_t state_r, state_nxt;
  logic [CNT_W-1:0] pix_r, nan_r, pos_r, use_r, zn_r;
  logic [SUM_W-1:0] psum_r, usum_r;
  logic [31:0]      min_r, max_r;
  logic [2:0]       job_r;
  // snapshot of closed frame
  logic [CNT_W-1:0] f_pix_r, f_nan_r, f_pos_r, f_use_r, f_zn_r;
  logic [SUM_W-1:0] f_psum_r, f_usum_r;
  logic [31:0]      f_min_r, f_max_r;
  logic [31:0]      r_mean_r, r_umean_r;
  logic [16:0]      r_vr_r, r_ur_r;
  logic             dv_start;
  logic [NUM_W-1:0] dv_num, dv_quot;
  logic [CNT_W-1:0] dv_den;
  logic             dv_busy;
  logic             take, close, o_valid;
  logic             started_r;
  logic             dv_busy_q_r, dv_finish;

  assign take    = q_valid && (state_r == ST_ACCUM);
  assign q_stall = (state_r != ST_ACCUM);
  assign close   = take && (q_item.last || (pix_r + 1'b1) == CNT_W'(MAX_PIX));

  dfs_divider #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quot(dv_quot)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCUM:  if (close) state_nxt = ST_ACCUM == ST_ACCUM ? ST_DIVIDE : ST_DIVIDE;
      ST_DIVIDE: if (!dv_busy && !dv_start && job_r == 3'd4) state_nxt = ST_OUTPUT;
      ST_OUTPUT: if (!out_stall) state_nxt = ST_ACCUM;
      default:   state_nxt = ST_ACCUM;
    endcase
  end

  // no start on the finish cycle: job_r only moves to the next division at that edge
  always_comb begin
    o_valid  = (state_r == ST_OUTPUT);
    dv_start = (state_r == ST_DIVIDE) && !dv_busy && !dv_finish && job_r < 3'd4
               && !started_r;
    dv_num   = '0;
    dv_den   = f_pix_r;
    unique case (job_r)
      3'd0: begin dv_num = NUM_W'(f_psum_r); dv_den = f_pos_r; end
      3'd1: begin dv_num = NUM_W'(f_usum_r); dv_den = f_use_r; end
      3'd2: dv_num = NUM_W'({f_pos_r, 16'd0});
      3'd3: dv_num = NUM_W'({f_use_r, 16'd0});
      default: dv_num = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACCUM;
      pix_r <= '0; nan_r <= '0; pos_r <= '0; use_r <= '0; zn_r <= '0;
      psum_r <= '0; usum_r <= '0; min_r <= DEPTH_ALL_ONES; max_r <= '0;
      job_r <= '0; started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= dv_start;
      if (close) begin
        pix_r <= '0; nan_r <= '0; pos_r <= '0; use_r <= '0; zn_r <= '0;
        psum_r <= '0; usum_r <= '0; min_r <= DEPTH_ALL_ONES; max_r <= '0;
        job_r <= '0;
      end else if (take) begin
        pix_r <= pix_r + 1'b1;
        unique case (q_item.cls)
          PIX_NAN_INF:  nan_r <= nan_r + 1'b1;
          PIX_ZERO_NEG: zn_r <= zn_r + 1'b1;
          PIX_USEFUL, PIX_FAR: begin
            pos_r  <= pos_r + 1'b1;
            psum_r <= psum_r + SUM_W'(q_item.depth);
            if (q_item.depth < min_r) min_r <= q_item.depth;
            if (q_item.depth > max_r) max_r <= q_item.depth;
            if (q_item.cls == PIX_USEFUL) begin
              use_r  <= use_r + 1'b1;
              usum_r <= usum_r + SUM_W'(q_item.depth);
            end
          end
          default: ;
        endcase
      end
      if (state_r == ST_DIVIDE && dv_finish) job_r <= job_r + 3'd1;
    end
  end

  // divider finishes on busy's falling edge
  assign dv_finish = dv_busy_q_r && !dv_busy;
  always_ff @(posedge clk) begin
    if (!rst_n) dv_busy_q_r <= 1'b0;
    else dv_busy_q_r <= dv_busy;
  end

  always_ff @(posedge clk) begin
    if (close) begin
      f_pix_r <= pix_r + 1'b1;
      f_nan_r <= nan_r + CNT_W'(q_item.cls == PIX_NAN_INF);
      f_zn_r  <= zn_r + CNT_W'(q_item.cls == PIX_ZERO_NEG);
      f_pos_r <= pos_r + CNT_W'(q_item.cls == PIX_USEFUL || q_item.cls == PIX_FAR);
      f_use_r <= use_r + CNT_W'(q_item.cls == PIX_USEFUL);
      f_psum_r <= psum_r + SUM_W'(q_item.depth);
      f_usum_r <= usum_r + ((q_item.cls == PIX_USEFUL) ? SUM_W'(q_item.depth) : '0);
      f_min_r <= ((q_item.cls == PIX_USEFUL || q_item.cls == PIX_FAR)
                  && q_item.depth < min_r) ? q_item.depth : min_r;
      f_max_r <= ((q_item.cls == PIX_USEFUL || q_item.cls == PIX_FAR)
                  && q_item.depth > max_r) ? q_item.depth : max_r;
    end
    if (state_r == ST_DIVIDE && dv_finish) begin
      unique case (job_r)
        3'd0: r_mean_r  <= (f_pos_r == '0) ? 32'd0 : dv_quot[31:0];
        3'd1: r_umean_r <= (f_use_r == '0) ? 32'd0 : dv_quot[31:0];
        3'd2: r_vr_r    <= dv_quot[16:0];
        3'd3: r_ur_r    <= dv_quot[16:0];
        default: ;
      endcase
    end
  end

  assign out_valid               = o_valid;
  assign out_total_pixels        = 22'(f_pix_r);
  assign out_nan_inf_count       = 22'(f_nan_r);
  assign out_positive_count      = 22'(f_pos_r);
  assign out_useful_count        = 22'(f_use_r);
  assign out_far_count           = 22'(f_pos_r - f_use_r);
  assign out_zero_negative_count = 22'(f_zn_r);
  assign out_min_depth           = (f_pos_r == '0) ? 32'd0 : f_min_r;
  assign out_max_depth           = (f_pos_r == '0) ? 32'd0 : f_max_r;
  assign out_mean_depth          = r_mean_r;
  assign out_mean_useful_depth   = r_umean_r;
  assign out_valid_ratio         = r_vr_r;
  assign out_useful_ratio        = r_ur_r;
endmodule

// File: rtl/core/depth_frame_statistics_core.sv
// depth_frame_statistics_core: per-frame depth pixel statistics
// a pixel passes a 3-stage front and the queue before it is counted; the last pixel of a
// frame closes it, and the back then computes and presents a result beat
// throughput: 1 pixel per cycle within a frame while the back accumulates; after each frame
// the back runs four divisions and holds its result until taken, stalling the queue
// synchronous active-low reset clears all counters, depth_mode 1, saturation 65 m
module depth_frame_statistics_core #(
  parameter int MAX_FRAME_PIXELS = 2097152
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_pixel_raw,
  input  logic        in_last_in_frame,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [21:0] out_total_pixels,
  output logic [21:0] out_nan_inf_count,
  output logic [21:0] out_positive_count,
  output logic [21:0] out_useful_count,
  output logic [21:0] out_far_count,
  output logic [21:0] out_zero_negative_count,
  output logic [31:0] out_min_depth,
  output logic [31:0] out_max_depth,
  output logic [31:0] out_mean_depth,
  output logic [31:0] out_mean_useful_depth,
  output logic [16:0] out_valid_ratio,
  output logic [16:0] out_useful_ratio,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dfs_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
  localparam int SUM_W = CNT_W + 32;

  logic        mode_r;
  logic [31:0] sat_r;
  logic        f_valid, f_stall, b_valid, b_stall;
  pix_item_t   f_item, b_item;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      sat_r  <= SAT_DEPTH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEPTH_MODE: mode_r <= cfg_data[0];
        REG_SAT_DEPTH:  sat_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  dfs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_raw(in_pixel_raw), .in_last_in_frame(in_last_in_frame),
    .depth_mode(mode_r), .saturation_depth(sat_r),
    .q_valid(f_valid), .q_item(f_item), .q_stall(f_stall)
  );

  dfs_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item),
    .rd_valid(b_valid), .rd_item(b_item), .rd_stall(b_stall)
  );

  dfs_back #(.CNT_W(CNT_W), .SUM_W(SUM_W), .MAX_PIX(MAX_FRAME_PIXELS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(b_valid), .q_stall(b_stall), .q_item(b_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_total_pixels(out_total_pixels), .out_nan_inf_count(out_nan_inf_count),
    .out_positive_count(out_positive_count), .out_useful_count(out_useful_count),
    .out_far_count(out_far_count), .out_zero_negative_count(out_zero_negative_count),
    .out_min_depth(out_min_depth), .out_max_depth(out_max_depth),
    .out_mean_depth(out_mean_depth), .out_mean_useful_depth(out_mean_useful_depth),
    .out_valid_ratio(out_valid_ratio), .out_useful_ratio(out_useful_ratio)
  );

  // a result always covers at least one pixel
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_pixels != 22'd0)
    else $error("empty frame result");

  // class counts add up to the frame total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 22'(out_nan_inf_count + out_positive_count + out_zero_negative_count)
                  == out_total_pixels)
    else $error("class counts do not sum to total");

  // useful pixels are a subset of positive ones
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_useful_count <= out_positive_count)
    else $error("useful count exceeds positive count");
endmodule
